FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds while reset is applied
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/nmea_rmc_pkg.sv
// shared types, character codes and scaling constants of the rmc parser
`timescale 1ns / 1ps
`default_nettype none

package nmea_rmc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [3:0] FLD_STATUS = 4'd2;
  localparam logic [3:0] FLD_LAT    = 4'd3;
  localparam logic [3:0] FLD_NS     = 4'd4;
  localparam logic [3:0] FLD_LON    = 4'd5;
  localparam logic [3:0] FLD_EW     = 4'd6;

  localparam logic [31:0] LAT_LIMIT = 32'd900000000;
  localparam logic [31:0] LON_LIMIT = 32'd1800000000;
  localparam logic [31:0] DEG_E7    = 32'd10000000;
  localparam logic [25:0] MS_SCALE  = 26'd50;

  // ceil(2^27 / 3): exact floor(x / 3) for any 26-bit x
  localparam logic [25:0] RECIP3       = 26'd44739243;
  localparam int          RECIP3_SHIFT = 27;
  localparam int          FRAC_W       = 24;

  typedef struct packed {
    logic        fix;
    logic [6:0]  lat_deg;
    logic [19:0] lat_ms;
    logic [7:0]  lon_deg;
    logic [19:0] lon_ms;
    logic [7:0]  ns;
    logic [7:0]  ew;
  } fix_raw_t;

  typedef struct packed {
    logic        fix;
    logic [7:0]  ns;
    logic [7:0]  ew;
    logic [29:0] lat_deg_e7;
    logic [31:0] lon_deg_e7;
    logic [25:0] lat_ms50;
    logic [25:0] lon_ms50;
  } fix_scaled_t;

  typedef struct packed {
    logic              fix;
    logic [7:0]        ns;
    logic [7:0]        ew;
    logic [29:0]       lat_deg_e7;
    logic [31:0]       lon_deg_e7;
    logic [FRAC_W-1:0] lat_frac;
    logic [FRAC_W-1:0] lon_frac;
  } fix_split_t;

  function automatic logic [3:0] digit_of(input logic [7:0] b);
    logic [7:0] diff;
    diff = b - CH_ZERO;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      return diff[3:0];
    end
    return 4'd0;
  endfunction

  // weight of each latitude minute digit, minutes scaled by 10000
  function automatic logic [16:0] lat_weight(input logic [3:0] k);
    case (k)
      4'd2:    return 17'd100000;
      4'd3:    return 17'd10000;
      4'd5:    return 17'd1000;
      4'd6:    return 17'd100;
      4'd7:    return 17'd10;
      4'd8:    return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] lon_weight(input logic [3:0] k);
    case (k)
      4'd3:    return 17'd100000;
      4'd4:    return 17'd10000;
      4'd6:    return 17'd1000;
      4'd7:    return 17'd100;
      4'd8:    return 17'd10;
      4'd9:    return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

  function automatic logic [6:0] lon_deg_weight(input logic [3:0] k);
    case (k)
      4'd0:    return 7'd100;
      4'd1:    return 7'd10;
      4'd2:    return 7'd1;
      default: return 7'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nmea_rmc_parse.sv
// byte-serial sentence tracker and field accumulator with a launch register
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_parse (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             rx_byte,
  input  wire logic                   launch_take,
  output logic                        launch_valid,
  output nmea_rmc_pkg::fix_raw_t      launch
);

  logic [2:0]  pos, pos_next;
  logic        header_match, header_match_next;
  logic [3:0]  field_num, field_num_next;
  logic [3:0]  cif, cif_next;
  logic        status_valid, status_valid_next;
  logic [6:0]  lat_deg, lat_deg_next;
  logic [19:0] lat_ms, lat_ms_next;
  logic [7:0]  lon_deg, lon_deg_next;
  logic [19:0] lon_ms, lon_ms_next;
  logic [7:0]  ns_pend, ns_pend_next;
  logic [7:0]  ew_pend, ew_pend_next;

  logic        accept;
  logic        emit;
  logic        do_clear;
  logic        hm_upd;
  logic [3:0]  d;
  logic [6:0]  lat_deg_inc;
  logic [19:0] lat_ms_inc;
  logic [19:0] lon_ms_inc;
  logic [10:0] lon_deg_sum;

  assign in_stall = launch_valid && !launch_take;
  assign accept   = in_valid && !in_stall;

  assign d           = nmea_rmc_pkg::digit_of(rx_byte);
  assign lat_deg_inc = (cif == 4'd0) ? 7'(d) * 7'd10 : 7'(d);
  assign lat_ms_inc  = 20'({17'd0, d} * {4'd0, nmea_rmc_pkg::lat_weight(cif)});
  assign lon_ms_inc  = 20'({17'd0, d} * {4'd0, nmea_rmc_pkg::lon_weight(cif)});
  assign lon_deg_sum = 11'(lon_deg) + 11'(d) * 11'(nmea_rmc_pkg::lon_deg_weight(cif));

  always_comb begin
    case (pos)
      3'd4:    hm_upd = (rx_byte == nmea_rmc_pkg::CH_M);
      3'd5:    hm_upd = header_match && (rx_byte == nmea_rmc_pkg::CH_C);
      default: hm_upd = header_match;
    endcase
  end

  always_comb begin
    pos_next          = pos;
    header_match_next = header_match;
    field_num_next    = field_num;
    cif_next          = cif;
    status_valid_next = status_valid;
    lat_deg_next      = lat_deg;
    lat_ms_next       = lat_ms;
    lon_deg_next      = lon_deg;
    lon_ms_next       = lon_ms;
    ns_pend_next      = ns_pend;
    ew_pend_next      = ew_pend;
    emit              = 1'b0;
    do_clear          = 1'b0;

    if (accept) begin
      if (rx_byte == nmea_rmc_pkg::CH_DOLLAR) begin
        do_clear = 1'b1;
        pos_next = 3'd1;
      end else if (pos != 3'd0) begin
        header_match_next = hm_upd;
        if (rx_byte == nmea_rmc_pkg::CH_LF && hm_upd && pos >= 3'd6) begin
          emit     = 1'b1;
          do_clear = 1'b1;
          pos_next = 3'd0;
        end else begin
          if (pos != 3'd7) begin
            pos_next = pos + 3'd1;
          end
          if (rx_byte == nmea_rmc_pkg::CH_COMMA) begin
            if (field_num != 4'd15) begin
              field_num_next = field_num + 4'd1;
            end
            cif_next = 4'd0;
          end else begin
            case (field_num)
              nmea_rmc_pkg::FLD_STATUS: begin
                if (cif == 4'd0) begin
                  status_valid_next = (rx_byte == nmea_rmc_pkg::CH_A);
                end
              end
              nmea_rmc_pkg::FLD_LAT: begin
                if (cif < 4'd2) begin
                  lat_deg_next = lat_deg + lat_deg_inc;
                end else if (cif < 4'd9) begin
                  lat_ms_next = lat_ms + lat_ms_inc;
                end
              end
              nmea_rmc_pkg::FLD_NS: begin
                if (cif == 4'd0) begin
                  ns_pend_next = rx_byte;
                end
              end
              nmea_rmc_pkg::FLD_LON: begin
                if (cif < 4'd3) begin
                  lon_deg_next = (lon_deg_sum > 11'd255) ? 8'hFF : lon_deg_sum[7:0];
                end else if (cif < 4'd10) begin
                  lon_ms_next = lon_ms + lon_ms_inc;
                end
              end
              nmea_rmc_pkg::FLD_EW: begin
                if (cif == 4'd0) begin
                  ew_pend_next = rx_byte;
                end
              end
              default: begin
              end
            endcase
            if (cif != 4'd15) begin
              cif_next = cif + 4'd1;
            end
          end
        end
      end
    end

    if (do_clear) begin
      header_match_next = 1'b0;
      field_num_next    = 4'd0;
      cif_next          = 4'd0;
      status_valid_next = 1'b0;
      lat_deg_next      = 7'd0;
      lat_ms_next       = 20'd0;
      lon_deg_next      = 8'd0;
      lon_ms_next       = 20'd0;
      ns_pend_next      = 8'd0;
      ew_pend_next      = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos          <= 3'd0;
      header_match <= 1'b0;
      field_num    <= 4'd0;
      cif          <= 4'd0;
      status_valid <= 1'b0;
      lat_deg      <= 7'd0;
      lat_ms       <= 20'd0;
      lon_deg      <= 8'd0;
      lon_ms       <= 20'd0;
      ns_pend      <= 8'd0;
      ew_pend      <= 8'd0;
    end else begin
      pos          <= pos_next;
      header_match <= header_match_next;
      field_num    <= field_num_next;
      cif          <= cif_next;
      status_valid <= status_valid_next;
      lat_deg      <= lat_deg_next;
      lat_ms       <= lat_ms_next;
      lon_deg      <= lon_deg_next;
      lon_ms       <= lon_ms_next;
      ns_pend      <= ns_pend_next;
      ew_pend      <= ew_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_valid <= 1'b0;
    end else if (emit) begin
      launch_valid <= 1'b1;
    end else if (launch_take) begin
      launch_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      launch.fix     <= status_valid;
      launch.lat_deg <= lat_deg;
      launch.lat_ms  <= lat_ms;
      launch.lon_deg <= lon_deg;
      launch.lon_ms  <= lon_ms;
      launch.ns      <= ns_pend;
      launch.ew      <= ew_pend;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/nmea_rmc_conv.sv
// fixed-point conversion pipeline and held position of the last valid fix
`timescale 1ns / 1ps
`default_nettype none

module nmea_rmc_conv (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   launch_valid,
  input  wire nmea_rmc_pkg::fix_raw_t launch,
  output logic                        launch_take,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic                        fix_valid,
  output logic signed [30:0]          latitude_e7,
  output logic signed [31:0]          longitude_e7,
  output logic [7:0]                  hemisphere_ns,
  output logic [7:0]                  hemisphere_ew
);

  logic                      v2;
  nmea_rmc_pkg::fix_scaled_t s2;
  logic                      v3;
  nmea_rmc_pkg::fix_split_t  s3;

  logic [30:0] last_lat;
  logic [31:0] last_lon;
  logic [7:0]  ns_char;
  logic [7:0]  ew_char;

  logic        out_free;
  logic        s3_free;
  logic        s2_free;

  logic [51:0] lat_prod;
  logic [51:0] lon_prod;
  logic [31:0] lat_mag;
  logic [31:0] lon_mag;
  logic [31:0] lat_clamp;
  logic [31:0] lon_clamp;
  logic [31:0] lat_val;
  logic [31:0] lon_val;

  // elastic stage control
  assign out_free    = !out_valid || !out_stall;
  assign s3_free     = !v3 || out_free;
  assign s2_free     = !v2 || s3_free;
  assign launch_take = s2_free;

  // divide by three through the reciprocal
  assign lat_prod = 52'(s2.lat_ms50) * 52'(nmea_rmc_pkg::RECIP3);
  assign lon_prod = 52'(s2.lon_ms50) * 52'(nmea_rmc_pkg::RECIP3);

  assign lat_mag   = 32'(s3.lat_deg_e7) + 32'(s3.lat_frac);
  assign lon_mag   = s3.lon_deg_e7 + 32'(s3.lon_frac);
  assign lat_clamp = (lat_mag > nmea_rmc_pkg::LAT_LIMIT) ? nmea_rmc_pkg::LAT_LIMIT : lat_mag;
  assign lon_clamp = (lon_mag > nmea_rmc_pkg::LON_LIMIT) ? nmea_rmc_pkg::LON_LIMIT : lon_mag;
  assign lat_val   = (s3.ns == nmea_rmc_pkg::CH_S) ? (32'd0 - lat_clamp) : lat_clamp;
  assign lon_val   = (s3.ew == nmea_rmc_pkg::CH_W) ? (32'd0 - lon_clamp) : lon_clamp;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s2_free) begin
        v2 <= launch_valid;
      end
      if (s3_free) begin
        v3 <= v2;
      end
      if (out_free) begin
        out_valid <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free) begin
      s2.fix        <= launch.fix;
      s2.ns         <= launch.ns;
      s2.ew         <= launch.ew;
      s2.lat_deg_e7 <= 30'(32'(launch.lat_deg) * nmea_rmc_pkg::DEG_E7);
      s2.lon_deg_e7 <= 32'(launch.lon_deg) * nmea_rmc_pkg::DEG_E7;
      s2.lat_ms50   <= 26'(launch.lat_ms) * nmea_rmc_pkg::MS_SCALE;
      s2.lon_ms50   <= 26'(launch.lon_ms) * nmea_rmc_pkg::MS_SCALE;
    end
    if (s3_free) begin
      s3.fix        <= s2.fix;
      s3.ns         <= s2.ns;
      s3.ew         <= s2.ew;
      s3.lat_deg_e7 <= s2.lat_deg_e7;
      s3.lon_deg_e7 <= s2.lon_deg_e7;
      s3.lat_frac   <= lat_prod[nmea_rmc_pkg::RECIP3_SHIFT +: nmea_rmc_pkg::FRAC_W];
      s3.lon_frac   <= lon_prod[nmea_rmc_pkg::RECIP3_SHIFT +: nmea_rmc_pkg::FRAC_W];
    end
  end

  // held position only moves when a valid fix leaves the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid <= 1'b0;
      last_lat  <= 31'd0;
      last_lon  <= 32'd0;
      ns_char   <= 8'd0;
      ew_char   <= 8'd0;
    end else if (out_free && v3) begin
      fix_valid <= s3.fix;
      if (s3.fix) begin
        last_lat <= lat_val[30:0];
        last_lon <= lon_val;
        ns_char  <= s3.ns;
        ew_char  <= s3.ew;
      end
    end
  end

  assign latitude_e7   = last_lat;
  assign longitude_e7  = last_lon;
  assign hemisphere_ns = ns_char;
  assign hemisphere_ew = ew_char;

endmodule

`default_nettype wire

FILE: rtl/core/nmea_rmc_position_parser_top.sv
// top level of the rmc position parser
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte of an NMEA 0183 stream per clock unless stalled and tracks
// RMC sentences field by field with no sentence buffer. The line feed that
// closes an RMC sentence yields one beat on the output: the fix flag and the
// last valid position in signed 1e-7 degree with its hemisphere letters. The
// line feed beat passes a launch register, a scaling stage (degrees times 1e7,
// minutes times 50), a divide-by-three stage and the add/clamp/sign stage that
// loads the output register. One byte is accepted every cycle while input
// stall is low; input stall rises only when the launch register still holds
// a result that the full conversion pipeline cannot take because the output
// is stalled.

module nmea_rmc_position_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             fix_valid,
  output logic signed [30:0] latitude_e7,
  output logic signed [31:0] longitude_e7,
  output logic [7:0]       hemisphere_ns,
  output logic [7:0]       hemisphere_ew
);

  logic                   launch_valid;
  logic                   launch_take;
  nmea_rmc_pkg::fix_raw_t launch;

  nmea_rmc_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .launch_take  (launch_take),
    .launch_valid (launch_valid),
    .launch       (launch)
  );

  nmea_rmc_conv u_conv (
    .clk           (clk),
    .rst           (rst),
    .launch_valid  (launch_valid),
    .launch        (launch),
    .launch_take   (launch_take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fix_valid     (fix_valid),
    .latitude_e7   (latitude_e7),
    .longitude_e7  (longitude_e7),
    .hemisphere_ns (hemisphere_ns),
    .hemisphere_ew (hemisphere_ew)
  );

endmodule

`default_nettype wire

FILE: rtl/core/nmea_rmc_checker.sv
// port-level checker of the rmc parser and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module nmea_rmc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic               fix_valid,
  input wire logic signed [30:0] latitude_e7,
  input wire logic signed [31:0] longitude_e7,
  input wire logic [7:0]         hemisphere_ns,
  input wire logic [7:0]         hemisphere_ew
);

  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid && !in_stall)

  `ASSERT_NEXT_CYCLE(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(fix_valid) && $stable(latitude_e7) && $stable(longitude_e7) && $stable(hemisphere_ns) && $stable(hemisphere_ew))

  `ASSERT_SAME_CYCLE(a_lat_range, clk, rst, out_valid, $signed(latitude_e7) >= -900000000 && $signed(latitude_e7) <= 900000000)

  `ASSERT_SAME_CYCLE(a_lon_range, clk, rst, out_valid, longitude_e7 >= -1800000000 && longitude_e7 <= 1800000000)

endmodule

bind nmea_rmc_position_parser_top nmea_rmc_checker u_checker (.*);

`default_nettype wire

FILE: sim/tb.sv
// self-checking testbench of the rmc position parser: byte stream stimulus, fix predictor, checks
`timescale 1ns / 1ps

module tb;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic        fix;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [7:0]  ns;
    logic [7:0]  ew;
  } rmc_fix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic out_valid;
  logic out_stall = 1'b0;
  logic fix_valid;
  logic signed [30:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic [7:0] hemisphere_ns;
  logic [7:0] hemisphere_ew;

  nmea_rmc_position_parser_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fix_valid     (fix_valid),
    .latitude_e7   (latitude_e7),
    .longitude_e7  (longitude_e7),
    .hemisphere_ns (hemisphere_ns),
    .hemisphere_ew (hemisphere_ew)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [7:0] byte_q[$];
  logic [7:0] line_buf[$];
  rmc_fix_t   fix_q[$];
  rmc_fix_t   want;
  int errors = 0;
  int n_fed = 0;
  int n_got = 0;
  int in_wait = 0;
  int out_wait = 0;
  int quiet_cycles = 0;

  // parser state
  logic [2:0]  s_pos = '0;
  logic        hdr_ok = 1'b0;
  logic [3:0]  fld = '0;
  logic [3:0]  chr = '0;
  logic        stat_a = 1'b0;
  logic [6:0]  lat_deg = '0;
  logic [19:0] lat_ms = '0;
  logic [7:0]  lon_deg = '0;
  logic [19:0] lon_ms = '0;
  logic [7:0]  ns_cur = '0;
  logic [7:0]  ew_cur = '0;
  logic [7:0]  ns_fix = '0;
  logic [7:0]  ew_fix = '0;
  logic [31:0] last_lat = '0;
  logic [31:0] last_lon = '0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void new_sentence();
    hdr_ok = 1'b0;
    fld = '0;
    chr = '0;
    stat_a = 1'b0;
    lat_deg = '0;
    lat_ms = '0;
    lon_deg = '0;
    lon_ms = '0;
    ns_cur = '0;
    ew_cur = '0;
  endfunction

  // weight of a minute digit, minutes scaled by 10000, k counted from the field start
  function automatic int minute_weight(input int k, input int start);
    case (k - start)
      0: return 100000;
      1: return 10000;
      3: return 1000;
      4: return 100;
      5: return 10;
      6: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] signed_e7(input longint deg, input longint ms,
                                            input longint lim, input bit neg);
    longint mag;
    logic [31:0] m32;
    mag = deg * 64'd10000000 + (ms * 50) / 3;
    if (mag > lim) mag = lim;
    m32 = mag[31:0];
    return neg ? 32'd0 - m32 : m32;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    rmc_fix_t f;
    int d;
    int acc;
    if (b == nmea_rmc_pkg::CH_DOLLAR) begin
      new_sentence();
      s_pos = 3'd1;
      return;
    end
    if (s_pos == 3'd0) return;
    if (s_pos == 3'd4) hdr_ok = (b == nmea_rmc_pkg::CH_M);
    else if (s_pos == 3'd5) hdr_ok = hdr_ok && (b == nmea_rmc_pkg::CH_C);
    if (b == nmea_rmc_pkg::CH_LF && hdr_ok && s_pos >= 3'd6) begin
      if (stat_a) begin
        last_lat = signed_e7(lat_deg, lat_ms, nmea_rmc_pkg::LAT_LIMIT,
                             ns_cur == nmea_rmc_pkg::CH_S);
        last_lon = signed_e7(lon_deg, lon_ms, nmea_rmc_pkg::LON_LIMIT,
                             ew_cur == nmea_rmc_pkg::CH_W);
        ns_fix = ns_cur;
        ew_fix = ew_cur;
      end
      f.fix = stat_a;
      f.lat = last_lat[30:0];
      f.lon = last_lon;
      f.ns = ns_fix;
      f.ew = ew_fix;
      fix_q.push_back(f);
      s_pos = 3'd0;
      new_sentence();
      return;
    end
    if (s_pos < 3'd7) s_pos++;
    if (b == nmea_rmc_pkg::CH_COMMA) begin
      if (fld < 4'd15) fld++;
      chr = '0;
      return;
    end
    d = (b >= nmea_rmc_pkg::CH_ZERO && b <= nmea_rmc_pkg::CH_NINE) ?
        int'(b - nmea_rmc_pkg::CH_ZERO) : 0;
    case (fld)
      nmea_rmc_pkg::FLD_STATUS: if (chr == 0) stat_a = (b == nmea_rmc_pkg::CH_A);
      nmea_rmc_pkg::FLD_LAT: begin
        if (chr == 0) lat_deg = 7'(lat_deg + d * 10);
        else if (chr == 1) lat_deg = 7'(lat_deg + d);
        else if (chr < 9) lat_ms = 20'(lat_ms + d * minute_weight(chr, 2));
      end
      nmea_rmc_pkg::FLD_NS: if (chr == 0) ns_cur = b;
      nmea_rmc_pkg::FLD_LON: begin
        if (chr < 3) begin
          acc = lon_deg + d * ((chr == 0) ? 100 : (chr == 1) ? 10 : 1);
          lon_deg = (acc > 255) ? 8'd255 : acc[7:0];
        end else if (chr < 10) begin
          lon_ms = 20'(lon_ms + d * minute_weight(chr, 3));
        end
      end
      nmea_rmc_pkg::FLD_EW: if (chr == 0) ew_cur = b;
      default: ;
    endcase
    if (chr < 4'd15) chr++;
  endfunction

  // sentence building
  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  function automatic void put_digits(input int n);
    for (int i = 0; i < n; i++)
      line_buf.push_back(8'(nmea_rmc_pkg::CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void flush_line();
    while (line_buf.size() != 0) byte_q.push_back(line_buf.pop_front());
  endfunction

  function automatic void end_line(input bit cr);
    if (cr) line_buf.push_back(8'h0D);
    line_buf.push_back(nmea_rmc_pkg::CH_LF);
    flush_line();
  endfunction

  function automatic void put_coord(input int int_len);
    int n;
    int fr;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, int_len + 2) : int_len;
    fr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 4;
    for (int i = 0; i < n; i++) begin
      if (i == 0 && $urandom_range(0, 4) != 0)
        line_buf.push_back(8'(nmea_rmc_pkg::CH_ZERO +
                              $urandom_range(0, (int_len == 2) ? 8 : 1)));
      else
        line_buf.push_back(8'(nmea_rmc_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    if (fr != 0 || $urandom_range(0, 1) != 0) put_str(".");
    put_digits(fr);
  endfunction

  function automatic void make_random_sentence();
    int r;
    int m;
    int cut;
    r = $urandom_range(0, 99);
    line_buf.push_back(nmea_rmc_pkg::CH_DOLLAR);
    if (r < 85) put_str($urandom_range(0, 1) ? "GPRMC" : "GNRMC");
    else if (r < 92) put_str("GPGGA");
    else repeat (5) line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
    put_str(",");
    if ($urandom_range(0, 3) != 0) begin
      put_digits(6);
      put_str(".");
      put_digits(2);
    end
    put_str(",");
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: put_str("A");
      6, 7: put_str("V");
      8: ;
      default: line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    endcase
    put_str(",");
    put_coord(2);
    put_str(",");
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_str("N");
      4, 5, 6, 7: put_str("S");
      8: ;
      default: line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
    endcase
    put_str(",");
    put_coord(3);
    put_str(",");
    case ($urandom_range(0, 9))
      0, 1, 2, 3: put_str("E");
      4, 5, 6, 7: put_str("W");
      8: ;
      default: line_buf.push_back(8'($urandom_range(8'h41, 8'h5A)));
    endcase
    if ($urandom_range(0, 1) != 0) begin
      put_str(",0.5,54.7,");
      put_digits(6);
      put_str(",,,A*");
      put_digits(2);
    end
    m = $urandom_range(0, 99);
    if (m < 8) begin
      cut = $urandom_range(1, line_buf.size() - 1);
      line_buf = line_buf[0:cut-1];
      end_line($urandom_range(0, 1) != 0);
    end else if (m < 14) begin
      line_buf[$urandom_range(1, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
      end_line($urandom_range(0, 3) != 0);
    end else if (m < 18) begin
      // broken off with no line end, the next dollar restarts
      cut = $urandom_range(1, line_buf.size() - 1);
      line_buf = line_buf[0:cut-1];
      flush_line();
    end else begin
      end_line($urandom_range(0, 3) != 0);
    end
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_wait = $urandom_range(0, 6);
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(rx_byte);
        n_fed++;
        in_wait = ((n_fed / 200) % 4 == 3) ? 0 : $urandom_range(0, 6);
      end
      if (!in_valid || !in_stall) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_got++;
        if (fix_q.size() == 0) begin
          flag_mismatch("result beat with no fix pending");
        end else begin
          want = fix_q.pop_front();
          if (fix_valid !== want.fix)
            flag_mismatch($sformatf("fix_valid %b, want %b", fix_valid, want.fix));
          if (latitude_e7 !== want.lat)
            flag_mismatch($sformatf("latitude_e7 %0d, want %0d", latitude_e7,
                                    $signed(want.lat)));
          if (longitude_e7 !== want.lon)
            flag_mismatch($sformatf("longitude_e7 %0d, want %0d", longitude_e7,
                                    $signed(want.lon)));
          if (hemisphere_ns !== want.ns)
            flag_mismatch($sformatf("hemisphere_ns %h, want %h", hemisphere_ns, want.ns));
          if (hemisphere_ew !== want.ew)
            flag_mismatch($sformatf("hemisphere_ew %h, want %h", hemisphere_ew, want.ew));
        end
        out_wait = ((n_got / 20) % 3 == 2) ? 0 : $urandom_range(0, 6);
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_stall <= (out_wait > 0);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    // idle bytes before any sentence
    put_str("idle,A,9");
    end_line(0);
    put_str("$GPRMC");
    end_line(0);
    put_str("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
    end_line(1);
    put_str("$GNRMC,0,A,3351.1234,S,15112.5678,W,,,");
    end_line(1);
    put_str("$GPRMC,1,V,1234.5678,N,12345.6789,E");
    end_line(0);
    put_str("$GPRMC,,A,9959.9999,S,99959.9999,W");
    end_line(0);
    put_str("$GPRMC,,A,0000.0000,N,00000.0000,E");
    end_line(0);
    put_str("$GPRMC,,A,4x0Z.a1b2,N,1#3:4.5/67,E");
    end_line(0);
    put_str("$GPRMC,,A,12345.678901234567,N,123456.78901234567,E");
    end_line(0);
    put_str("$GPRMC,,A,4530.5");
    end_line(0);
    put_str("$GPRMC,,A,1000.0000,,02000.0000,");
    end_line(0);
    put_str("$GPRMC,,B,1111.1111,N,02222.2222,E");
    end_line(0);
    put_str("$GPRMC,,AV,2222.2222,S,03333.3333,E");
    end_line(1);
    put_str("$GPGGA,,A,1111.1111,N,02222.2222,E");
    end_line(0);
    put_str("$GPRMB,,A,1,N,2,E");
    end_line(0);
    put_str("$GPXMC");
    end_line(0);
    // restart in the middle of a sentence
    put_str("$GPRMC,,A,12");
    flush_line();
    put_str("$GPRMC,,A,5000.0000,N,00100.0000,E");
    end_line(1);
    put_str("$GPR");
    end_line(0);
    put_str("$GPRM");
    end_line(0);
    put_str("$GPRMC,");
    line_buf.push_back(8'hFF);
    put_str(",A,");
    line_buf.push_back(8'h00);
    put_str("123.4567,N,");
    line_buf.push_back(8'hFF);
    put_str("0000.0,E");
    end_line(0);
    put_str("$GPRMC,,,,,,,,,,,,,,,,,,,,A");
    end_line(0);
    repeat (8) begin
      put_str("$GPRMC");
      end_line(0);
    end
    while (byte_q.size() < 1500) make_random_sentence();

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (byte_q.size() != 0 || in_valid) @(posedge clk);
    while (fix_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/nmea_rmc_pkg.sv
rtl/core/nmea_rmc_parse.sv
rtl/core/nmea_rmc_conv.sv
rtl/core/nmea_rmc_position_parser_top.sv
rtl/core/nmea_rmc_checker.sv
sim/tb.sv
